/* hdl/kmer_clump_finder_assert.svh */
`ifndef KMER_CLUMP_FINDER_ASSERT_SVH
`define KMER_CLUMP_FINDER_ASSERT_SVH

// Clocked property, disabled while reset is asserted.
`define KCF_ASSERT(lbl, ck, rn, prop, msg) \
	lbl: assert property (@(posedge ck) disable iff (!rn) prop) else $error(msg);

// Same-cycle implication, disabled while reset is asserted.
`define KCF_ASSERT_IMPL(lbl, ck, rn, ante, cons, msg) \
	lbl: assert property (@(posedge ck) disable iff (!rn) (ante) |-> (cons)) else $error(msg);

`endif

/* hdl/kcf_pkg.sv */
package kcf_pkg;

	localparam int DEF_MAX_KMER     = 8;
	localparam int DEF_WINDOW_DEPTH = 1024;

	localparam int BASE_W     = 2;
	localparam int KLEN_W     = 4;
	localparam int WLEN_W     = 11;
	localparam int THR_W      = 11;
	localparam int CNT_W      = 11;
	localparam int SEEN_W     = 11;
	localparam int CFG_IDX_W  = 2;
	localparam int CFG_DATA_W = 11;

	localparam int OUT_DEPTH = 4;
	localparam int OUT_AW    = 2;

	localparam logic [CFG_IDX_W-1:0] REG_KMER_LEN   = CFG_IDX_W'(0);
	localparam logic [CFG_IDX_W-1:0] REG_WINDOW_LEN = CFG_IDX_W'(1);
	localparam logic [CFG_IDX_W-1:0] REG_THRESHOLD  = CFG_IDX_W'(2);

	localparam logic [KLEN_W-1:0] KMER_LEN_RST   = KLEN_W'(5);
	localparam logic [WLEN_W-1:0] WINDOW_LEN_RST = WLEN_W'(500);
	localparam logic [THR_W-1:0]  THRESHOLD_RST  = THR_W'(3);

	// Per-item control handed from the front stage to the count unit
	typedef struct packed {
		logic vld;
		logic dep_go;
		logic arr_en;
	} kcf_ctl_t;

endpackage

/* hdl/kcf_ring.sv */
module kcf_ring #(
	parameter int DEPTH = 1024,
	parameter int DW    = 17
) (
	input  logic                     clk,
	input  logic                     wr_en,
	input  logic [$clog2(DEPTH)-1:0] wr_addr,
	input  logic [DW-1:0]            wr_data,
	input  logic [$clog2(DEPTH)-1:0] rd_addr,
	output logic [DW-1:0]            rd_data
);

	logic [DW-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		rd_data <= mem[rd_addr];
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
	end

endmodule

/* hdl/kcf_count_unit.sv */
module kcf_count_unit import kcf_pkg::*; #(
	parameter int CODE_W = 2 * DEF_MAX_KMER
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              clr_en,
	input  logic [CODE_W-1:0] clr_addr,
	input  kcf_ctl_t          ctl,
	input  logic [CODE_W-1:0] dep_code,
	input  logic [CODE_W-1:0] arr_code,
	input  logic [THR_W-1:0]  thr,
	output logic              res_vld,
	output logic              res_found,
	output logic [CODE_W-1:0] res_code,
	output logic [CODE_W:0]   res_total
);

	localparam int DEPTH = 2 ** CODE_W;
	localparam int EW    = CNT_W + 1;

	logic [EW-1:0] mem [DEPTH];
	logic [EW-1:0] rd_q;

	logic              vld_s2, dep_s2, arr_en_s2;
	logic [CODE_W-1:0] dep_addr_s2, code_s2;
	logic              vld_s3, arr_s3;
	logic [CODE_W-1:0] code_s3;

	logic              fwd_vld_q;
	logic [CODE_W-1:0] fwd_addr_q;
	logic [EW-1:0]     fwd_data_q;
	logic [CODE_W:0]   total_q, total_next;

	logic [CODE_W-1:0] rd_addr, cur_addr, wr_addr;
	logic [EW-1:0]     cur, wr_data;
	logic              wr_en, cur_flag, hit;
	logic [CNT_W-1:0]  cur_cnt, dec_cnt, inc_cnt;

	always_comb begin
		// arrival read of an item wins; a departure read never falls in the same cycle
		rd_addr  = (vld_s2 && arr_en_s2) ? code_s2 : dep_code;
		cur_addr = dep_s2 ? dep_addr_s2 : code_s3;
		// forward the write made at the edge this read was issued
		cur      = (fwd_vld_q && fwd_addr_q == cur_addr) ? fwd_data_q : rd_q;
		cur_cnt  = cur[CNT_W-1:0];
		cur_flag = cur[CNT_W];
		dec_cnt  = (cur_cnt == '0) ? '0 : cur_cnt - CNT_W'(1);
		inc_cnt  = (cur_cnt == '1) ? cur_cnt : cur_cnt + CNT_W'(1);
		hit      = arr_s3 && (inc_cnt >= thr) && !cur_flag;
	end

	always_comb begin
		wr_en   = 1'b0;
		wr_addr = cur_addr;
		wr_data = '0;
		if (clr_en) begin
			wr_en   = 1'b1;
			wr_addr = clr_addr;
		end else if (dep_s2) begin
			wr_en   = 1'b1;
			wr_data = {cur_flag, dec_cnt};
		end else if (arr_s3) begin
			wr_en   = 1'b1;
			wr_data = {cur_flag | hit, inc_cnt};
		end
	end

	assign total_next = (hit && total_q != '1) ? total_q + (CODE_W + 1)'(1) : total_q;
	assign res_vld    = vld_s3;
	assign res_found  = hit;
	assign res_code   = hit ? code_s3 : '0;
	assign res_total  = total_next;

	always_ff @(posedge clk) begin
		rd_q <= mem[rd_addr];
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s2    <= 1'b0;
			dep_s2    <= 1'b0;
			vld_s3    <= 1'b0;
			arr_s3    <= 1'b0;
			fwd_vld_q <= 1'b0;
			total_q   <= '0;
		end else begin
			vld_s2    <= ctl.vld;
			dep_s2    <= ctl.vld & ctl.dep_go;
			vld_s3    <= vld_s2;
			arr_s3    <= vld_s2 & arr_en_s2;
			fwd_vld_q <= wr_en;
			total_q   <= total_next;
		end
	end

	always_ff @(posedge clk) begin
		arr_en_s2   <= ctl.arr_en;
		dep_addr_s2 <= dep_code;
		code_s2     <= arr_code;
		code_s3     <= code_s2;
		fwd_addr_q  <= wr_addr;
		fwd_data_q  <= wr_data;
	end

endmodule

/* hdl/kcf_result_fifo.sv */
module kcf_result_fifo import kcf_pkg::*; #(
	parameter int W = 34
) (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         push,
	input  logic [W-1:0] push_data,
	input  logic         pop,
	output logic         valid,
	output logic [W-1:0] data
);

	logic [W-1:0]      slot_q [OUT_DEPTH];
	logic [OUT_AW-1:0] wr_q, rd_q;
	logic [OUT_AW:0]   cnt_q;

	assign valid = (cnt_q != '0);
	assign data  = slot_q[rd_q];

	always_ff @(posedge clk) begin
		if (push) begin
			slot_q[wr_q] <= push_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= '0;
			rd_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (push) begin
				wr_q <= wr_q + OUT_AW'(1);
			end
			if (pop) begin
				rd_q <= rd_q + OUT_AW'(1);
			end
			if (push && !pop) begin
				cnt_q <= cnt_q + (OUT_AW + 1)'(1);
			end else if (pop && !push) begin
				cnt_q <= cnt_q - (OUT_AW + 1)'(1);
			end
		end
	end

endmodule

/* hdl/kmer_clump_finder.sv */
// Sliding-window k-mer clump finder. One 2-bit base (A=0, C=1, G=2, T=3) is taken per
// input transaction and exactly one result transaction comes back for it, in order:
// clump_found, the code of the k-mer reported (first base in the high bits, zero when
// nothing is reported) and the running count of distinct reported k-mers. in_ready stays
// low while the base before is in the front stage; the single read port of the count
// memory sets this, since each base does one read-modify-write for the k-mer leaving the
// window and one for the k-mer just completed. A result passes the front stage, the count
// unit's stages s2 and s3 and the result FIFO before it shows on the output, and at most
// four bases may be in flight or waiting as results before the input stalls. After reset
// the block clears its count, flag and window memories, sweeping them with a counter of
// max(2*MAX_KMER, log2(WINDOW_DEPTH)) bits and holds in_ready low meanwhile; configuration
// writes are taken at any time, but must only be made while the block is idle.
module kmer_clump_finder import kcf_pkg::*; #(
	parameter int MAX_KMER     = DEF_MAX_KMER,
	parameter int WINDOW_DEPTH = DEF_WINDOW_DEPTH
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  cfg_valid,
	output logic                  cfg_ready,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_data,
	input  logic                  in_valid,
	output logic                  in_ready,
	input  logic [BASE_W-1:0]     base,
	output logic                  out_valid,
	input  logic                  out_ready,
	output logic                  clump_found,
	output logic [2*MAX_KMER-1:0] clump_kmer,
	output logic [2*MAX_KMER:0]   clump_total
);

	localparam int CODE_W = 2 * MAX_KMER;
	localparam int RAW    = $clog2(WINDOW_DEPTH);
	localparam int PW     = (RAW + 1 > WLEN_W) ? RAW + 1 : WLEN_W;
	localparam int SW     = (CODE_W > RAW) ? CODE_W : RAW;
	localparam int RES_W  = 2 * CODE_W + 2;

	logic [KLEN_W-1:0] kmer_len_q;
	logic [WLEN_W-1:0] window_len_q;
	logic [THR_W-1:0]  threshold_q;

	logic          clr_q;
	logic [SW-1:0] clr_cnt_q;

	logic [CODE_W-1:0] shift_q;
	logic [SEEN_W-1:0] seen_q;
	logic [RAW-1:0]    ptr_q;
	logic [OUT_AW:0]   occ_q;

	logic              vld_s1, dep_en_s1, arr_en_s1, s_eq_p_s1;
	logic [RAW-1:0]    s_s1;
	logic [CODE_W-1:0] code_s1;

	logic [KLEN_W-1:0]   k_eff;
	logic [PW-1:0]       w_eff, k_ext, d, p_ext, s_full;
	logic [RAW-1:0]      s;
	logic [CODE_W-1:0]   mask, shift_next;
	logic [CODE_W+1:0]   shift_cat;
	logic                dep_en, arr_en, accept, pop;
	logic [THR_W-1:0]    thr_eff;
	logic [RAW-1:0]      ptr_next;

	logic              ring_wr_en;
	logic [RAW-1:0]    ring_wr_addr;
	logic [CODE_W:0]   ring_wr_data, ring_rd;

	kcf_ctl_t          ctl;
	logic              res_vld, res_found;
	logic [CODE_W-1:0] res_code;
	logic [CODE_W:0]   res_total;
	logic [RES_W-1:0]  out_data;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			kmer_len_q   <= KMER_LEN_RST;
			window_len_q <= WINDOW_LEN_RST;
			threshold_q  <= THRESHOLD_RST;
		end else if (cfg_valid) begin
			unique case (cfg_index)
				REG_KMER_LEN:   kmer_len_q   <= cfg_data[KLEN_W-1:0];
				REG_WINDOW_LEN: window_len_q <= cfg_data[WLEN_W-1:0];
				REG_THRESHOLD:  threshold_q  <= cfg_data[THR_W-1:0];
				default: ;
			endcase
		end
	end

	// Effective settings, the slot of the departing k-mer and the next shift and pointer values
	always_comb begin
		if (kmer_len_q == '0) begin
			k_eff = KLEN_W'(1);
		end else if (kmer_len_q > KLEN_W'(MAX_KMER)) begin
			k_eff = KLEN_W'(MAX_KMER);
		end else begin
			k_eff = kmer_len_q;
		end
		if (window_len_q == '0) begin
			w_eff = PW'(1);
		end else if (PW'(window_len_q) > PW'(WINDOW_DEPTH)) begin
			w_eff = PW'(WINDOW_DEPTH);
		end else begin
			w_eff = PW'(window_len_q);
		end
		thr_eff = (threshold_q == '0) ? THR_W'(1) : threshold_q;
		k_ext   = PW'(k_eff);
		dep_en  = (w_eff >= k_ext);
		d       = w_eff - k_ext + PW'(1);
		p_ext   = PW'(ptr_q);
		s_full  = (p_ext >= d) ? p_ext - d : p_ext + PW'(WINDOW_DEPTH) - d;
		s       = s_full[RAW-1:0];
		for (int i = 0; i < MAX_KMER; i++) begin
			mask[2*i +: 2] = {2{KLEN_W'(i) < k_eff}};
		end
		shift_cat  = {shift_q, base};
		shift_next = shift_cat[CODE_W-1:0] & mask;
		arr_en     = ({1'b0, seen_q} + (SEEN_W + 1)'(1)) >= (SEEN_W + 1)'(k_eff);
		ptr_next   = (ptr_q == RAW'(WINDOW_DEPTH - 1)) ? '0 : ptr_q + RAW'(1);
	end

	assign in_ready = !clr_q && !vld_s1 && (occ_q != (OUT_AW + 1)'(OUT_DEPTH));
	assign accept   = in_valid && in_ready;
	assign pop      = out_valid && out_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clr_q     <= 1'b1;
			clr_cnt_q <= '0;
			shift_q   <= '0;
			seen_q    <= '0;
			ptr_q     <= '0;
			occ_q     <= '0;
			vld_s1    <= 1'b0;
		end else begin
			if (clr_q) begin
				clr_cnt_q <= clr_cnt_q + SW'(1);
				if (clr_cnt_q == '1) begin
					clr_q <= 1'b0;
				end
			end
			if (accept) begin
				shift_q <= shift_next;
				ptr_q   <= ptr_next;
				if (seen_q != '1) begin
					seen_q <= seen_q + SEEN_W'(1);
				end
			end
			if (accept && !pop) begin
				occ_q <= occ_q + (OUT_AW + 1)'(1);
			end else if (pop && !accept) begin
				occ_q <= occ_q - (OUT_AW + 1)'(1);
			end
			vld_s1 <= accept;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			dep_en_s1 <= dep_en;
			arr_en_s1 <= arr_en;
			s_eq_p_s1 <= (s == ptr_q);
			s_s1      <= s;
			code_s1   <= shift_next;
		end
	end

	// One ring write per edge: sweep, arrival slot on accept, departed slot in the cycle after
	always_comb begin
		ring_wr_en   = 1'b0;
		ring_wr_addr = s_s1;
		ring_wr_data = '0;
		if (clr_q) begin
			ring_wr_en   = ({1'b0, clr_cnt_q} < (SW + 1)'(WINDOW_DEPTH));
			ring_wr_addr = clr_cnt_q[RAW-1:0];
		end else if (accept) begin
			ring_wr_en   = 1'b1;
			ring_wr_addr = ptr_q;
			ring_wr_data = {arr_en, shift_next};
		end else if (vld_s1 && dep_en_s1 && !s_eq_p_s1) begin
			ring_wr_en = 1'b1;
		end
	end

	kcf_ring #(
		.DEPTH (WINDOW_DEPTH),
		.DW    (CODE_W + 1)
	) u_ring (
		.clk     (clk),
		.wr_en   (ring_wr_en),
		.wr_addr (ring_wr_addr),
		.wr_data (ring_wr_data),
		.rd_addr (s),
		.rd_data (ring_rd)
	);

	always_comb begin
		ctl.vld    = vld_s1;
		ctl.dep_go = dep_en_s1 & ring_rd[CODE_W];
		ctl.arr_en = arr_en_s1;
	end

	kcf_count_unit #(
		.CODE_W (CODE_W)
	) u_count (
		.clk       (clk),
		.arst_n    (arst_n),
		.clr_en    (clr_q),
		.clr_addr  (clr_cnt_q[CODE_W-1:0]),
		.ctl       (ctl),
		.dep_code  (ring_rd[CODE_W-1:0]),
		.arr_code  (code_s1),
		.thr       (thr_eff),
		.res_vld   (res_vld),
		.res_found (res_found),
		.res_code  (res_code),
		.res_total (res_total)
	);

	kcf_result_fifo #(
		.W (RES_W)
	) u_fifo (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (res_vld),
		.push_data ({res_found, res_code, res_total}),
		.pop       (pop),
		.valid     (out_valid),
		.data      (out_data)
	);

	assign clump_found = out_data[RES_W-1];
	assign clump_kmer  = out_data[RES_W-2 -: CODE_W];
	assign clump_total = out_data[CODE_W:0];

endmodule

/* hdl/kcf_checker.sv */
`include "kmer_clump_finder_assert.svh"

module kcf_checker import kcf_pkg::*; #(
	parameter int MAX_KMER = DEF_MAX_KMER
) (
	input logic                  clk,
	input logic                  arst_n,
	input logic                  in_valid,
	input logic                  in_ready,
	input logic                  out_valid,
	input logic                  out_ready,
	input logic                  clump_found,
	input logic [2*MAX_KMER-1:0] clump_kmer,
	input logic [2*MAX_KMER:0]   clump_total
);

	// memories are still being swept right after reset
	`KCF_ASSERT(a_busy_after_reset, clk, arst_n, !$past(arst_n) |-> !in_ready, "input ready during clear")
	`KCF_ASSERT(a_item_spacing, clk, arst_n, in_valid && in_ready |=> !in_ready, "bases closer than two cycles")
	`KCF_ASSERT_IMPL(a_kmer_zero, clk, arst_n, out_valid && !clump_found, clump_kmer == '0, "k-mer code without clump")
	`KCF_ASSERT_IMPL(a_total_counts, clk, arst_n, out_valid && clump_found, clump_total != '0, "clump with zero total")
	`KCF_ASSERT(a_out_hold, clk, arst_n, out_valid && !out_ready |=> out_valid && $stable(clump_total), "stalled result changed")

endmodule

bind kmer_clump_finder kcf_checker #(.MAX_KMER(MAX_KMER)) u_kcf_checker (.*);
